/* sv/scp_pkg.sv */
// Shared types and constants for the sample clock period picker.
package scp_pkg;

  localparam int CLOCK_REGS       = 4;
  localparam int TOP_SHIFT        = 3;
  localparam int MAX_CLOCKS_DEF   = 4;
  localparam int DIVISOR_STEPS_DEF = 4;

  localparam int PERIOD_W = 16;
  localparam int REQ_W    = 20;
  localparam int ACT_W    = 19;
  localparam int IDX_W    = 2;
  localparam int CNT_W    = 3;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_0 = 3'd0,
    REG_PERIOD_1 = 3'd1,
    REG_PERIOD_2 = 3'd2,
    REG_PERIOD_3 = 3'd3,
    REG_COUNT    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    RND_NEAREST = 2'd0,
    RND_UP      = 2'd1,
    RND_DOWN    = 2'd2
  } round_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_WALK,
    ST_PICK
  } state_t;

  typedef struct packed {
    logic [REQ_W-1:0] requested_period;
    logic [1:0]       round_mode;
  } req_t;

  typedef struct packed {
    logic [ACT_W-1:0] actual_period;
    logic [IDX_W-1:0] clock_select;
    logic [1:0]       divisor_shift;
  } res_t;

  typedef struct packed {
    logic [CLOCK_REGS-1:0][PERIOD_W-1:0] period;
    logic [CNT_W-1:0]                    count;
  } cfg_t;

  typedef struct packed {
    logic take_up;
    logic take_dn;
  } cand_t;

endpackage

/* sv/scp_cfg_regs.sv */
// Configuration register file: master clock periods and clock count.
module scp_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [scp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scp_pkg::PERIOD_W-1:0]  cfg_data,
  output scp_pkg::cfg_t              cfg
);
  import scp_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period[0] <= 16'd31250;
      cfg.period[1] <= 16'd22676;
      cfg.period[2] <= 16'd20833;
      cfg.period[3] <= 16'd19531;
      cfg.count     <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_PERIOD_0: cfg.period[0] <= cfg_data;
        REG_PERIOD_1: cfg.period[1] <= cfg_data;
        REG_PERIOD_2: cfg.period[2] <= cfg_data;
        REG_PERIOD_3: cfg.period[3] <= cfg_data;
        REG_COUNT:    cfg.count     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/scp_cand_unit.sv */
// Shared compare unit: scales one clock period and tests it against both candidates.
module scp_cand_unit (
  input  logic [scp_pkg::PERIOD_W-1:0] period,
  input  logic [1:0]                   shift,
  input  logic [scp_pkg::ACT_W-1:0]    req,
  input  logic [scp_pkg::ACT_W-1:0]    up,
  input  logic [scp_pkg::ACT_W-1:0]    dn,
  output logic [scp_pkg::ACT_W-1:0]    scaled,
  output scp_pkg::cand_t               cand
);
  import scp_pkg::*;

  assign scaled       = {3'b000, period} << shift;
  assign cand.take_up = (scaled < up) && (scaled >= req);
  assign cand.take_dn = (scaled > dn) && (scaled <= req);

endmodule

/* sv/scp_seq.sv */
// Sequencer: clamps the request, walks divisor/clock pairs, then rounds.
module scp_seq #(
  parameter int MAX_CLOCKS    = scp_pkg::MAX_CLOCKS_DEF,
  parameter int DIVISOR_STEPS = scp_pkg::DIVISOR_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  scp_pkg::req_t request,
  input  scp_pkg::cfg_t cfg,
  output logic          result_strobe,
  output scp_pkg::res_t result
);
  import scp_pkg::*;

  localparam int CLK_LIMIT   = (MAX_CLOCKS < CLOCK_REGS) ? MAX_CLOCKS : CLOCK_REGS;
  localparam int SHIFT_STEPS = (DIVISOR_STEPS < TOP_SHIFT + 1) ? DIVISOR_STEPS : TOP_SHIFT + 1;
  localparam logic [1:0] S_LAST = 2'(SHIFT_STEPS - 1);

  state_t state, state_next;

  logic [REQ_W-1:0] req_raw;
  logic [1:0]       mode;
  logic [ACT_W-1:0] req;
  logic [ACT_W-1:0] up, dn;
  logic [IDX_W-1:0] up_idx, dn_idx;
  logic [1:0]       up_sh, dn_sh;
  logic [IDX_W-1:0] c;
  logic [1:0]       s;

  logic [CNT_W-1:0] n_clk;
  logic [IDX_W-1:0] last;
  logic [ACT_W-1:0] up_init, dn_init, req_clamp;
  logic [REQ_W-1:0] req_lo;
  logic [ACT_W-1:0] scaled;
  cand_t            cand;
  logic             zero_clk, row_end;
  logic signed [ACT_W+1:0] d_up, d_dn;
  logic [ACT_W-1:0] chosen;

  // usable clock count, at least one
  always_comb begin
    n_clk = cfg.count;
    if (n_clk == '0) n_clk = CNT_W'(1);
    if (n_clk > CNT_W'(CLK_LIMIT)) n_clk = CNT_W'(CLK_LIMIT);
    last = IDX_W'(n_clk - CNT_W'(1));
  end

  always_comb begin
    up_init = {cfg.period[0], 3'b000};
    dn_init = {3'b000, cfg.period[last]};
    req_lo  = (req_raw < {4'b0000, dn_init[PERIOD_W-1:0]}) ?
              {4'b0000, dn_init[PERIOD_W-1:0]} : req_raw;
    req_clamp = (req_lo > {1'b0, up_init}) ? up_init : req_lo[ACT_W-1:0];
  end

  scp_cand_unit u_cand (
    .period (cfg.period[c]),
    .shift  (s),
    .req    (req),
    .up     (up),
    .dn     (dn),
    .scaled (scaled),
    .cand   (cand)
  );

  assign zero_clk = (cfg.period[c] == '0);
  assign row_end  = zero_clk || (c == last);

  always_comb begin
    d_up = $signed({2'b00, up}) - $signed({2'b00, req});
    d_dn = $signed({2'b00, req}) - $signed({2'b00, dn});
    case (round_mode_t'(mode))
      RND_UP:   chosen = up;
      RND_DOWN: chosen = dn;
      default:  chosen = (d_up < d_dn) ? up : dn;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_INIT;
      ST_INIT: state_next = ST_WALK;
      ST_WALK: if (row_end && (s == S_LAST)) state_next = ST_PICK;
      ST_PICK: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) result_strobe <= 1'b0;
    else     result_strobe <= (state == ST_PICK);
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (start) begin
          req_raw <= request.requested_period;
          mode    <= request.round_mode;
        end
      end
      ST_INIT: begin
        req    <= req_clamp;
        up     <= up_init;
        up_idx <= '0;
        up_sh  <= 2'(TOP_SHIFT);
        dn     <= dn_init;
        dn_idx <= last;
        dn_sh  <= '0;
        c      <= '0;
        s      <= '0;
      end
      ST_WALK: begin
        if (!zero_clk && cand.take_up) begin
          up     <= scaled;
          up_idx <= c;
          up_sh  <= s;
        end
        if (!zero_clk && cand.take_dn) begin
          dn     <= scaled;
          dn_idx <= c;
          dn_sh  <= s;
        end
        if (row_end) begin
          c <= '0;
          s <= s + 2'd1;
        end else begin
          c <= c + IDX_W'(1);
        end
      end
      ST_PICK: begin
        result.actual_period <= chosen;
        result.clock_select  <= (chosen == up) ? up_idx : dn_idx;
        result.divisor_shift <= (chosen == up) ? up_sh : dn_sh;
      end
      default: ;
    endcase
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && state == ST_INIT))
    else $error("accepted request did not start the sequence");

  a_up_above_req: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK || state == ST_PICK) |-> (up >= req))
    else $error("upper candidate below clamped request");

  a_result_cand: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PICK) |=> (result.actual_period == $past(up) ||
                           result.actual_period == $past(dn)))
    else $error("result is neither candidate");

endmodule

/* sv/sample_clock_period_picker.sv */
// Top level of the sample clock period picker.
//
//  channel   | handshake              | payload
//  ----------+------------------------+------------------------------------
//  request   | start / busy           | request (requested_period, round_mode)
//  result    | result_strobe          | result (actual_period, clock_select,
//            |                        |         divisor_shift)
//  config    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A request steps through the INIT, WALK and PICK states; in WALK the single compare
// unit tests one clock/divisor pair per cycle.
// busy is high from the cycle after acceptance until the result is driven.
// The result strobe lasts one cycle; the receiver cannot stall it.
// Reset restores the default clock table; cfg_ready is always high.
module sample_clock_period_picker #(
  parameter int MAX_CLOCKS    = scp_pkg::MAX_CLOCKS_DEF,
  parameter int DIVISOR_STEPS = scp_pkg::DIVISOR_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  scp_pkg::req_t                 request,
  output logic                          result_strobe,
  output scp_pkg::res_t                 result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [scp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scp_pkg::PERIOD_W-1:0]  cfg_data
);
  import scp_pkg::*;

  cfg_t cfg;

  scp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  scp_seq #(
    .MAX_CLOCKS    (MAX_CLOCKS),
    .DIVISOR_STEPS (DIVISOR_STEPS)
  ) u_seq (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .cfg           (cfg),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule
